/* rtl/ibm_pkg.sv */
package ibm_pkg;

    // Fixed field widths of the two channels.
    localparam int IN_W = 9;
    localparam int PB_W = 10;
    localparam int ST_W = 2;

    // Default geometry, handed to the top level as parameter defaults.
    localparam int DEF_DIRECT_PTRS    = 11;
    localparam int DEF_PTRS_PER_BLOCK = 16;
    localparam int DEF_POOL_BLOCKS    = 1024;

    // Result status codes.
    localparam logic [ST_W-1:0] ST_EXISTING  = 2'd0;
    localparam logic [ST_W-1:0] ST_NEW       = 2'd1;
    localparam logic [ST_W-1:0] ST_OOR       = 2'd2;
    localparam logic [ST_W-1:0] ST_EXHAUSTED = 2'd3;

    // Fraction bits of the reciprocal used to split the double-indirect offset.
    localparam int DIV_S = 16;

    localparam int UACT_W  = 4;
    localparam int UCOND_W = 3;
    localparam int UPC_W   = 4;

    typedef logic [UACT_W-1:0]  uact_t;
    typedef logic [UCOND_W-1:0] ucond_t;
    typedef logic [UPC_W-1:0]   upc_t;

    typedef struct packed {
        uact_t  act;
        ucond_t cond;
        upc_t   target;
    } uword_t;

    // Datapath actions.
    localparam uact_t A_NOP      = 4'd0;
    localparam uact_t A_CLEAR    = 4'd1;
    localparam uact_t A_ACCEPT   = 4'd2;
    localparam uact_t A_CLASSIFY = 4'd3;
    localparam uact_t A_DIVFIX   = 4'd4;
    localparam uact_t A_ROOT     = 4'd5;
    localparam uact_t A_SRD      = 4'd6;
    localparam uact_t A_SCHK     = 4'd7;
    localparam uact_t A_EMIT     = 4'd8;

    // Jump conditions; a false condition falls through to the next step.
    localparam ucond_t C_ALWAYS   = 3'd0;
    localparam ucond_t C_CLR_BUSY = 3'd1;
    localparam ucond_t C_NO_IN    = 3'd2;
    localparam ucond_t C_OOR      = 3'd3;
    localparam ucond_t C_DONE     = 3'd4;
    localparam ucond_t C_MORE     = 3'd5;
    localparam ucond_t C_OUT_FREE = 3'd6;

    // Program steps.
    localparam upc_t P_CLEAR    = 4'd0;
    localparam upc_t P_WAIT     = 4'd1;
    localparam upc_t P_CLASSIFY = 4'd2;
    localparam upc_t P_DIVFIX   = 4'd3;
    localparam upc_t P_ROOT     = 4'd4;
    localparam upc_t P_SRD      = 4'd5;
    localparam upc_t P_SCHK     = 4'd6;
    localparam upc_t P_EMIT     = 4'd7;
    localparam upc_t P_HOLD     = 4'd8;

    // The control store: one word per step.
    function automatic uword_t ucode_rom(upc_t pc);
        uword_t w;
        case (pc)
            P_CLEAR:    w = '{act: A_CLEAR,    cond: C_CLR_BUSY, target: P_CLEAR};
            P_WAIT:     w = '{act: A_ACCEPT,   cond: C_NO_IN,    target: P_WAIT};
            P_CLASSIFY: w = '{act: A_CLASSIFY, cond: C_OOR,      target: P_EMIT};
            P_DIVFIX:   w = '{act: A_DIVFIX,   cond: C_ALWAYS,   target: P_ROOT};
            P_ROOT:     w = '{act: A_ROOT,     cond: C_DONE,     target: P_EMIT};
            P_SRD:      w = '{act: A_SRD,      cond: C_ALWAYS,   target: P_SCHK};
            P_SCHK:     w = '{act: A_SCHK,     cond: C_MORE,     target: P_SRD};
            P_EMIT:     w = '{act: A_EMIT,     cond: C_OUT_FREE, target: P_WAIT};
            P_HOLD:     w = '{act: A_NOP,      cond: C_ALWAYS,   target: P_EMIT};
            default:    w = '{act: A_NOP,      cond: C_ALWAYS,   target: P_WAIT};
        endcase
        return w;
    endfunction

endpackage

/* rtl/ibm_if.sv */
interface ibm_req_if
    import ibm_pkg::*;
;
    logic            valid;
    logic            ready;
    logic [IN_W-1:0] logical_block;

    modport source (output valid, output logical_block, input ready);
    modport sink   (input valid, input logical_block, output ready);
endinterface

interface ibm_rsp_if
    import ibm_pkg::*;
;
    logic            valid;
    logic            ready;
    logic [PB_W-1:0] physical_block;
    logic [ST_W-1:0] status;

    modport source (output valid, output physical_block, output status, input ready);
    modport sink   (input valid, input physical_block, input status, output ready);
endinterface

/* rtl/inode_block_map_allocate.sv */
// Channel | Dir | Payload                         | Transfer when
// --------+-----+---------------------------------+------------------------
// req     | in  | logical_block[8:0]              | req.valid && req.ready
// rsp     | out | physical_block[9:0], status[1:0] | rsp.valid && rsp.ready
//
// A request is taken at the accept step and passes the classify, divide-fix,
// root and emit steps; an out-of-range block goes from classify straight to
// emit, and each pointer-store level of an indirect walk adds a read step on
// the registered read port of the store and a check step.
// After reset the pointer store is swept to zero, one entry a cycle, over all
// POOL_BLOCKS * PTRS_PER_BLOCK entries (16384 by default); req.ready stays low.
// A result waits in the output register; a new request is taken meanwhile, and
// the sequencer only waits at its final step if the previous result is unread.
module inode_block_map_allocate
    import ibm_pkg::*;
#(
    parameter int DIRECT_PTRS    = DEF_DIRECT_PTRS,
    parameter int PTRS_PER_BLOCK = DEF_PTRS_PER_BLOCK,
    parameter int POOL_BLOCKS    = DEF_POOL_BLOCKS
)
(
    input  logic     clk,
    input  logic     rst_n,
    ibm_req_if.sink  req,
    ibm_rsp_if.source rsp
);

    localparam int ROOT_DEPTH  = DIRECT_PTRS + 2;
    localparam int STORE_DEPTH = POOL_BLOCKS * PTRS_PER_BLOCK;
    localparam int RIDX_W      = $clog2(ROOT_DEPTH);
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int BLK_W       = $clog2(POOL_BLOCKS);
    localparam int NF_W        = $clog2(POOL_BLOCKS + 1);
    localparam int SLOT_W      = $clog2(PTRS_PER_BLOCK);
    localparam int PROD_W      = IN_W + DIV_S;
    localparam int DIV_M       = (1 << DIV_S) / PTRS_PER_BLOCK;

    localparam logic [31:0] D32    = 32'(DIRECT_PTRS);
    localparam logic [31:0] PPB32  = 32'(PTRS_PER_BLOCK);
    localparam logic [31:0] SPAN32 = 32'(PTRS_PER_BLOCK * PTRS_PER_BLOCK);

    localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(STORE_DEPTH - 1);
    localparam logic [NF_W-1:0]   NF_FULL  = NF_W'(POOL_BLOCKS);

    // Sequencer.
    upc_t   upc_reg;
    upc_t   upc_next;
    uword_t uw;
    logic   cond_true;

    // Request decode.
    logic [IN_W-1:0]   lb_reg;
    logic [IN_W-1:0]   r_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [1:0]        lvl_reg;
    logic [RIDX_W-1:0] root_idx_reg;
    logic [SLOT_W-1:0] slot_hi_reg;
    logic [SLOT_W-1:0] slot_lo_reg;

    // Walk.
    logic [BLK_W-1:0]  cur_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [BLK_W-1:0]  mem_rd_reg;
    logic [NF_W-1:0]   nf_reg;
    logic [ADDR_W-1:0] clr_reg;
    logic [BLK_W-1:0]  root_reg [ROOT_DEPTH];
    logic              oor_reg;
    logic              exh_reg;
    logic              fresh_reg;

    // Output register.
    logic              out_valid_reg;
    logic [PB_W-1:0]   out_pb_reg;
    logic [ST_W-1:0]   out_st_reg;

    // Pointer store.
    logic [BLK_W-1:0]  store_mem [STORE_DEPTH];

    logic [31:0]       lb32;
    logic              is_direct;
    logic              is_single;
    logic              is_double;
    logic              oor_now;
    logic [31:0]       r_now;
    logic [RIDX_W-1:0] root_idx_now;
    logic [1:0]        lvl_now;
    logic [IN_W-1:0]   q_est;
    logic [31:0]       rem0;
    logic              div_fix;
    logic [31:0]       q_fix;
    logic [31:0]       rem_fix;
    logic [SLOT_W-1:0] slot_sel;
    logic [ADDR_W-1:0] addr_now;
    logic [BLK_W-1:0]  val_in;
    logic              need;
    logic              pool_full;
    logic              exh_now;
    logic              alloc;
    logic [BLK_W-1:0]  new_val;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_wa;
    logic [BLK_W-1:0]  mem_wd;
    logic              out_free;
    logic              emit_fire;

    assign uw = ucode_rom(upc_reg);

    // Region of the logical block: direct, single-indirect, double-indirect or
    // beyond the mapped range.
    always_comb
    begin
        lb32      = 32'(lb_reg);
        is_direct = lb32 < D32;
        is_single = !is_direct && ((lb32 - D32) < PPB32);
        is_double = !is_direct && !is_single && ((lb32 - D32 - PPB32) < SPAN32);
        oor_now   = !is_direct && !is_single && !is_double;
        r_now     = is_double ? (lb32 - D32 - PPB32) : (lb32 - D32);
        if (is_direct)
        begin
            root_idx_now = lb_reg[RIDX_W-1:0];
            lvl_now      = 2'd0;
        end
        else if (is_single)
        begin
            root_idx_now = RIDX_W'(DIRECT_PTRS);
            lvl_now      = 2'd1;
        end
        else
        begin
            root_idx_now = RIDX_W'(DIRECT_PTRS + 1);
            lvl_now      = 2'd2;
        end
    end

    // Quotient from the reciprocal product may be one short; one correction
    // step puts it right.
    always_comb
    begin
        q_est   = prod_reg[PROD_W-1:DIV_S];
        rem0    = 32'(r_reg) - 32'(q_est) * PPB32;
        div_fix = rem0 >= PPB32;
        q_fix   = div_fix ? 32'(q_est) + 32'd1 : 32'(q_est);
        rem_fix = div_fix ? rem0 - PPB32 : rem0;
    end

    assign slot_sel = (lvl_reg == 2'd2) ? slot_hi_reg : slot_lo_reg;
    assign addr_now = ADDR_W'(32'(cur_reg) * PPB32 + 32'(slot_sel));

    // Shared allocate-on-miss logic for the root entry and the store slots.
    assign val_in    = (uw.act == A_ROOT) ? root_reg[root_idx_reg] : mem_rd_reg;
    assign need      = (val_in == '0);
    assign pool_full = (nf_reg >= NF_FULL);
    assign exh_now   = need && pool_full;
    assign alloc     = need && !pool_full;
    assign new_val   = need ? BLK_W'(nf_reg) : val_in;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign emit_fire = (uw.act == A_EMIT) && out_free;

    always_comb
    begin
        case (uw.cond)
            C_ALWAYS:   cond_true = 1'b1;
            C_CLR_BUSY: cond_true = clr_reg != CLR_LAST;
            C_NO_IN:    cond_true = !req.valid;
            C_OOR:      cond_true = oor_now;
            C_DONE:     cond_true = exh_now || (lvl_reg == 2'd0);
            C_MORE:     cond_true = !exh_now && (lvl_reg == 2'd2);
            C_OUT_FREE: cond_true = out_free;
            default:    cond_true = 1'b0;
        endcase
        upc_next = cond_true ? uw.target : upc_reg + UPC_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg       <= P_CLEAR;
            nf_reg        <= NF_W'(1);
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < ROOT_DEPTH; i++)
            begin
                root_reg[i] <= '0;
            end
        end
        else
        begin
            upc_reg <= upc_next;
            if (uw.act == A_CLEAR)
            begin
                clr_reg <= clr_reg + ADDR_W'(1);
            end
            if (((uw.act == A_ROOT) || (uw.act == A_SCHK)) && alloc)
            begin
                nf_reg <= nf_reg + NF_W'(1);
            end
            if ((uw.act == A_ROOT) && alloc)
            begin
                root_reg[root_idx_reg] <= new_val;
            end
            if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (emit_fire)
            begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    // Datapath registers without reset.
    always_ff @(posedge clk)
    begin
        case (uw.act)
            A_ACCEPT:
            begin
                lb_reg <= req.logical_block;
            end
            A_CLASSIFY:
            begin
                r_reg        <= IN_W'(r_now);
                prod_reg     <= PROD_W'(r_now) * PROD_W'(DIV_M);
                lvl_reg      <= lvl_now;
                root_idx_reg <= root_idx_now;
                oor_reg      <= oor_now;
                exh_reg      <= 1'b0;
                fresh_reg    <= 1'b0;
            end
            A_DIVFIX:
            begin
                slot_hi_reg <= SLOT_W'(q_fix);
                slot_lo_reg <= (lvl_reg == 2'd2) ? SLOT_W'(rem_fix) : SLOT_W'(r_reg);
            end
            A_ROOT:
            begin
                cur_reg   <= new_val;
                exh_reg   <= exh_now;
                fresh_reg <= need;
            end
            A_SRD:
            begin
                addr_reg <= addr_now;
            end
            A_SCHK:
            begin
                cur_reg   <= new_val;
                exh_reg   <= exh_now;
                fresh_reg <= need;
                lvl_reg   <= lvl_reg - 2'd1;
            end
            A_EMIT:
            begin
                if (out_free)
                begin
                    if (oor_reg)
                    begin
                        out_pb_reg <= '0;
                        out_st_reg <= ST_OOR;
                    end
                    else if (exh_reg)
                    begin
                        out_pb_reg <= '0;
                        out_st_reg <= ST_EXHAUSTED;
                    end
                    else
                    begin
                        out_pb_reg <= PB_W'(32'(cur_reg));
                        out_st_reg <= fresh_reg ? ST_NEW : ST_EXISTING;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Pointer store: one write port shared by the clearing sweep and the
    // allocation write-back, one registered read port.
    assign mem_we = (uw.act == A_CLEAR) || ((uw.act == A_SCHK) && alloc);
    assign mem_wa = (uw.act == A_CLEAR) ? clr_reg : addr_reg;
    assign mem_wd = (uw.act == A_CLEAR) ? '0 : new_val;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[mem_wa] <= mem_wd;
        end
        if (uw.act == A_SRD)
        begin
            mem_rd_reg <= store_mem[addr_now];
        end
    end

    assign req.ready          = (upc_reg == P_WAIT);
    assign rsp.valid          = out_valid_reg;
    assign rsp.physical_block = out_pb_reg;
    assign rsp.status         = out_st_reg;

    // The allocator never hands out block 0 and never runs past the pool.
    a_nf_range: assert property (@(posedge clk) disable iff (!rst_n)
        (nf_reg != '0) && (nf_reg <= NF_FULL))
        else $error("free-block counter out of range");

    // At most one block is allocated per cycle.
    a_nf_step: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> ((nf_reg == $past(nf_reg)) || (nf_reg == $past(nf_reg) + NF_W'(1))))
        else $error("free-block counter jumped");

    // An exhaustion result can only be shown once the pool is used up.
    a_exh_full: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status == ST_EXHAUSTED)) |-> (nf_reg == NF_FULL))
        else $error("exhaustion reported with free blocks left");

endmodule
